// ----- src/first_fit_block_allocator_defines.svh -----
// assertion macros for the first-fit block allocator
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define FFBA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FFBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFBA_ASSERT(lbl, clk, rst, prop, msg)
`define FFBA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- src/ffba_pkg.sv -----
`timescale 1ns / 1ps

package ffba_pkg;

  // field widths
  localparam int ADDR_W  = 20;
  localparam int SIZE_W  = 20;
  localparam int BASE_W  = 21;
  localparam int LIMIT_W = 21;

  // parameter defaults
  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 24;
  localparam int ADDR_BITS_DEF    = 20;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 21'h100000;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REALLOC = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERO    = 2'd1,
    ST_FULL    = 2'd2,
    ST_BADFREE = 2'd3
  } status_t;

  // what the shared compare unit looks for
  typedef enum logic {
    MODE_FIT  = 1'b0,
    MODE_FIND = 1'b1
  } mode_t;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic [SIZE_W-1:0] size;
    logic              free;
  } entry_t;

endpackage

// ----- src/ffba_table.sv -----
`timescale 1ns / 1ps

module ffba_table #(
  parameter int DEPTH = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int IDXW  = $clog2(ffba_pkg::MAX_BLOCKS_DEF)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDXW-1:0]  wr_idx,
  input  ffba_pkg::entry_t wr_entry,
  input  logic             rd_en,
  input  logic [IDXW-1:0]  rd_idx,
  output ffba_pkg::entry_t rd_entry
);

  ffba_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry <= mem[rd_idx];
    end
  end

endmodule

// ----- src/ffba_match.sv -----
`timescale 1ns / 1ps

module ffba_match #(
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
  input  ffba_pkg::mode_t              mode,
  input  ffba_pkg::entry_t             entry,
  input  logic [ffba_pkg::SIZE_W-1:0]  key_size,
  input  logic [ffba_pkg::ADDR_W-1:0]  key_addr,
  output logic                         hit
);

  localparam int SUMW = ffba_pkg::BASE_W + 1;

  logic [SUMW-1:0] payload;
  logic            fit_ok;
  logic            addr_ok;

  // free block large enough, or block base plus header lands on the key address
  assign payload = {1'b0, entry.base} + SUMW'(HEADER_BYTES);
  assign fit_ok  = entry.free && (entry.size >= key_size);
  assign addr_ok = (payload == SUMW'(key_addr));

  always_comb begin
    case (mode)
      ffba_pkg::MODE_FIT:  hit = fit_ok;
      ffba_pkg::MODE_FIND: hit = addr_ok;
      default:             hit = 1'b0;
    endcase
  end

endmodule

// ----- src/first_fit_block_allocator.sv -----
`timescale 1ns / 1ps
// First-fit heap block allocator. Each request (allocate, free, reallocate) walks the
// block table one entry per cycle through a single read port and one shared compare
// unit. The walk covers the entries below count, the number of blocks in the table;
// a hit ends the walk early. A reallocate that has to move walks the table twice,
// once to find the old block and once to place the new one. Zero-size allocates,
// null frees and unused opcodes skip the walk and go straight to the result.
// The block takes one request at a time; the result sits in an output register,
// so the next request can be taken while the previous result waits.
// heap_limit may only be written while no request is in flight. Table entries hold
// no reset value; only entries below the block count are ever looked at.

`include "first_fit_block_allocator_defines.svh"

module first_fit_block_allocator #(
  parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
  parameter int ADDR_BITS    = ffba_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    opcode,
  input  logic [ffba_pkg::SIZE_W-1:0]   request_size,
  input  logic [ffba_pkg::ADDR_W-1:0]   payload_address,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ffba_pkg::ADDR_W-1:0]   result_address,
  output logic [1:0]                    status,
  output logic                          moved,
  output logic [ffba_pkg::SIZE_W-1:0]   copy_length,
  // heap limit register write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ffba_pkg::LIMIT_W-1:0]  cfg_data
);

  localparam int AW   = ffba_pkg::ADDR_W;
  localparam int SW   = ffba_pkg::SIZE_W;
  localparam int LW   = ffba_pkg::LIMIT_W;
  localparam int SUMW = LW + 1;
  localparam int IDXW = $clog2(MAX_BLOCKS);
  localparam int CNTW = $clog2(MAX_BLOCKS + 1);

  // address mask and address space cap
  localparam logic [63:0] AMASK64 = (64'd1 << ADDR_BITS) - 64'd1;
  localparam logic [63:0] CAP64   = (ADDR_BITS < LW) ? (64'd1 << ADDR_BITS)
                                                     : ((64'd1 << LW) - 64'd1);
  localparam logic [SUMW-1:0] HDR = SUMW'(HEADER_BYTES);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SCAN    = 5'b00010,
    S_APPEND  = 5'b00100,
    S_RELEASE = 5'b01000,
    S_DONE    = 5'b10000
  } state_t;

  state_t state;

  // heap bookkeeping
  logic [CNTW-1:0] count;
  logic [LW-1:0]   brk;
  logic [LW-1:0]   heap_limit;

  // request in flight
  ffba_pkg::opcode_t op_r;
  logic [SW-1:0]     size_r;
  logic [AW-1:0]     addr_r;
  ffba_pkg::mode_t   mode;
  logic              is_realloc;  // fit scan belongs to a moving reallocate

  // scan pointer and read pipeline
  logic [CNTW-1:0] idx;
  logic            pend;
  logic [IDXW-1:0] pend_idx;

  // old block of a moving reallocate
  logic [IDXW-1:0]   k_idx;
  ffba_pkg::entry_t  k_entry;

  // working result
  logic [AW-1:0]     w_addr;
  ffba_pkg::status_t w_status;
  logic              w_moved;
  logic [SW-1:0]     w_copy;

  // table ports
  logic              rd_en;
  ffba_pkg::entry_t  rd_entry;
  logic              wr_en;
  logic [IDXW-1:0]   wr_idx;
  ffba_pkg::entry_t  wr_entry;

  logic              hit;
  logic              scan_hit;
  logic              scan_miss;
  logic              move_start;
  logic [AW-1:0]     addr_in;
  logic [AW-1:0]     entry_payload;
  logic [AW-1:0]     brk_payload;
  logic [LW-1:0]     eff_limit;
  logic [SUMW-1:0]   grow_sum;
  logic              room;
  logic              alloc_path;

  function automatic logic opcode_t_is_alloc(input logic [1:0] op, input logic [AW-1:0] a);
    logic r;
    r = (op == ffba_pkg::OP_ALLOC) || ((op == ffba_pkg::OP_REALLOC) && (a == '0));
    return r;
  endfunction

  ffba_table #(
    .DEPTH (MAX_BLOCKS),
    .IDXW  (IDXW)
  ) u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_idx   (wr_idx),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_idx   (idx[IDXW-1:0]),
    .rd_entry (rd_entry)
  );

  // shared compare unit, looks at the entry read the cycle before
  ffba_match #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_match (
    .mode     (mode),
    .entry    (rd_entry),
    .key_size (size_r),
    .key_addr (addr_r),
    .hit      (hit)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign addr_in    = payload_address & AMASK64[AW-1:0];
  assign alloc_path = (opcode_t_is_alloc(opcode, addr_in));

  // scan: read idx this cycle, compare the entry fetched last cycle
  assign rd_en     = (state == S_SCAN) && (idx < count);
  assign scan_hit  = (state == S_SCAN) && pend && hit;
  assign scan_miss = (state == S_SCAN) && !pend && !rd_en;

  // old block found but too small, the walk starts over as a fit search
  assign move_start = scan_hit && (mode == ffba_pkg::MODE_FIND) && !rd_entry.free &&
                      (op_r == ffba_pkg::OP_REALLOC) && (rd_entry.size < size_r);

  assign entry_payload = AW'({1'b0, rd_entry.base} + HDR);
  assign brk_payload   = AW'({1'b0, brk} + HDR);

  // growth check against the table depth and the smaller of heap_limit and the address space
  assign eff_limit = (heap_limit > CAP64[LW-1:0]) ? CAP64[LW-1:0] : heap_limit;
  assign grow_sum  = {1'b0, brk} + HDR + SUMW'(size_r);
  assign room      = (count != CNTW'(MAX_BLOCKS)) && (grow_sum <= {1'b0, eff_limit});

  // table write port
  always_comb begin
    wr_en    = 1'b0;
    wr_idx   = pend_idx;
    wr_entry = rd_entry;
    case (state)
      S_SCAN: begin
        if (scan_hit) begin
          if (mode == ffba_pkg::MODE_FIT) begin
            // take the free block whole
            wr_en         = 1'b1;
            wr_entry.free = 1'b0;
          end else if (!rd_entry.free && (op_r == ffba_pkg::OP_FREE)) begin
            wr_en         = 1'b1;
            wr_entry.free = 1'b1;
          end
        end
      end
      S_APPEND: begin
        // new block at the break
        wr_en    = room;
        wr_idx   = count[IDXW-1:0];
        wr_entry = '{base: brk, size: size_r, free: 1'b0};
      end
      S_RELEASE: begin
        // old block of a moved reallocate goes free
        wr_en         = 1'b1;
        wr_idx        = k_idx;
        wr_entry      = k_entry;
        wr_entry.free = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // heap limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit <= ffba_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      heap_limit <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      brk       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a handover in S_DONE refills the output register itself
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r       <= ffba_pkg::opcode_t'(opcode);
            size_r     <= request_size;
            addr_r     <= addr_in;
            idx        <= '0;
            pend       <= 1'b0;
            is_realloc <= 1'b0;
            w_addr     <= '0;
            w_moved    <= 1'b0;
            w_copy     <= '0;
            if (alloc_path && (request_size == '0)) begin
              w_status <= ffba_pkg::ST_ZERO;
            end else begin
              w_status <= ffba_pkg::ST_OK;
            end
            if (alloc_path) begin
              mode <= ffba_pkg::MODE_FIT;
              if (request_size == '0) begin
                state <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end else begin
              mode <= ffba_pkg::MODE_FIND;
              case (ffba_pkg::opcode_t'(opcode))
                ffba_pkg::OP_FREE: begin
                  // null free does nothing
                  state <= (addr_in == '0) ? S_DONE : S_SCAN;
                end
                ffba_pkg::OP_REALLOC: begin
                  state <= S_SCAN;
                end
                default: begin
                  state <= S_DONE;
                end
              endcase
            end
          end
        end

        S_SCAN: begin
          if (move_start) begin
            idx  <= '0;
            pend <= 1'b0;
          end else begin
            idx  <= idx + CNTW'(rd_en);
            pend <= rd_en;
          end
          pend_idx <= idx[IDXW-1:0];
          if (scan_hit) begin
            if (mode == ffba_pkg::MODE_FIT) begin
              w_addr <= entry_payload;
              if (is_realloc) begin
                w_moved <= 1'b1;
                w_copy  <= k_entry.size;
                state   <= S_RELEASE;
              end else begin
                state <= S_DONE;
              end
            end else if (rd_entry.free) begin
              // double free or reallocate of a free block
              w_status <= ffba_pkg::ST_BADFREE;
              state    <= S_DONE;
            end else if (op_r == ffba_pkg::OP_FREE) begin
              state <= S_DONE;
            end else if (rd_entry.size >= size_r) begin
              // block already large enough, keep it
              w_addr <= addr_r;
              state  <= S_DONE;
            end else begin
              // remember the old block, restart the walk as a fit search
              k_idx      <= pend_idx;
              k_entry    <= rd_entry;
              is_realloc <= 1'b1;
              mode       <= ffba_pkg::MODE_FIT;
            end
          end else if (scan_miss) begin
            if (mode == ffba_pkg::MODE_FIT) begin
              state <= S_APPEND;
            end else begin
              w_status <= ffba_pkg::ST_BADFREE;
              state    <= S_DONE;
            end
          end
        end

        S_APPEND: begin
          if (room) begin
            count  <= count + 1'b1;
            brk    <= grow_sum[LW-1:0];
            w_addr <= brk_payload;
            if (is_realloc) begin
              w_moved <= 1'b1;
              w_copy  <= k_entry.size;
              state   <= S_RELEASE;
            end else begin
              state <= S_DONE;
            end
          end else begin
            // limit reached or table full
            w_status <= ffba_pkg::ST_FULL;
            state    <= S_DONE;
          end
        end

        S_RELEASE: begin
          state <= S_DONE;
        end

        S_DONE: begin
          // hand over once the output register is free
          if (!out_valid || out_ready) begin
            result_address <= w_addr;
            status         <= w_status;
            moved          <= w_moved;
            copy_length    <= w_copy;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `FFBA_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> (state == S_IDLE) && !out_valid && (count == '0), "not idle after reset")
  `FFBA_ASSERT(a_count_bound, clk, rst, count <= CNTW'(MAX_BLOCKS), "block count past table depth")
  `FFBA_ASSERT(a_grow_step, clk, rst, !$past(rst) && (count != $past(count)) |-> (count == $past(count) + 1'b1) && (brk > $past(brk)), "block count moved without break growth")
  `FFBA_ASSERT(a_wr_busy, clk, rst, wr_en |-> (state != S_IDLE) && (state != S_DONE), "table written outside a request")
  `FFBA_ASSERT(a_moved_ok, clk, rst, out_valid && moved |-> (status == ffba_pkg::ST_OK), "move reported with error status")
  `FFBA_ASSERT(a_full_null, clk, rst, out_valid && (status == ffba_pkg::ST_FULL) |-> (result_address == '0) && !moved, "failed allocate returned an address")

endmodule

// ----- tb/heap_reply_checker.sv -----
`timescale 1ns / 1ps

module heap_reply_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [1:0]                   opcode,
  input  logic [ffba_pkg::SIZE_W-1:0]  request_size,
  input  logic [ffba_pkg::ADDR_W-1:0]  payload_address,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [ffba_pkg::ADDR_W-1:0]  result_address,
  input  logic [1:0]                   status,
  input  logic                         moved,
  input  logic [ffba_pkg::SIZE_W-1:0]  copy_length,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [ffba_pkg::LIMIT_W-1:0] cfg_data,
  output int                           fail_count,
  output int                           pending
);

  localparam int AW    = ffba_pkg::ADDR_W;
  localparam int SW    = ffba_pkg::SIZE_W;
  localparam int BW    = ffba_pkg::BASE_W;
  localparam int LW    = ffba_pkg::LIMIT_W;
  localparam int HDR   = ffba_pkg::HEADER_BYTES_DEF;
  localparam int DEPTH = ffba_pkg::MAX_BLOCKS_DEF;
  localparam logic [22:0] SPAN = 23'(1) << ffba_pkg::ADDR_BITS_DEF;

  typedef struct {
    logic [AW-1:0]     address;
    ffba_pkg::status_t status;
    logic              moved;
    logic [SW-1:0]     copy;
  } heap_reply_t;

  logic [BW-1:0]  base_tab [DEPTH];
  logic [SW-1:0]  size_tab [DEPTH];
  logic           free_tab [DEPTH];
  int             blocks_used;
  logic [BW-1:0]  brk;
  logic [LW-1:0]  limit_reg;
  heap_reply_t    replies_due [$];

  // first fit over the table, else append at the break
  function automatic int claim_block(input logic [SW-1:0] size,
                                     output ffba_pkg::status_t st);
    logic [22:0] lim;
    logic [22:0] need;
    st = ffba_pkg::ST_OK;
    if (size == '0) begin
      st = ffba_pkg::ST_ZERO;
      return -1;
    end
    for (int i = 0; i < blocks_used; i++) begin
      if (free_tab[i] && size_tab[i] >= size) begin
        free_tab[i] = 1'b0;
        return i;
      end
    end
    lim  = (23'(limit_reg) > SPAN) ? SPAN : 23'(limit_reg);
    need = 23'(brk) + 23'(HDR) + 23'(size);
    if (blocks_used >= DEPTH || need > lim) begin
      st = ffba_pkg::ST_FULL;
      return -1;
    end
    base_tab[blocks_used] = brk;
    size_tab[blocks_used] = size;
    free_tab[blocks_used] = 1'b0;
    brk = BW'(need);
    blocks_used++;
    return blocks_used - 1;
  endfunction

  // table slot of the allocated block whose payload sits at addr
  function automatic int find_live(input logic [AW-1:0] addr);
    for (int i = 0; i < blocks_used; i++) begin
      if (23'(base_tab[i]) + 23'(HDR) == 23'(addr))
        return free_tab[i] ? -1 : i;
    end
    return -1;
  endfunction

  function automatic heap_reply_t heap_step(input logic [1:0] op,
                                            input logic [SW-1:0] size,
                                            input logic [AW-1:0] addr);
    heap_reply_t       r;
    ffba_pkg::status_t st;
    int                k;
    int                n;
    r.address = '0;
    r.status  = ffba_pkg::ST_OK;
    r.moved   = 1'b0;
    r.copy    = '0;
    if (op == ffba_pkg::OP_ALLOC || (op == ffba_pkg::OP_REALLOC && addr == '0)) begin
      k = claim_block(size, st);
      r.status = st;
      if (k >= 0)
        r.address = AW'(base_tab[k] + HDR);
    end else if (op == ffba_pkg::OP_FREE) begin
      if (addr != '0) begin
        k = find_live(addr);
        if (k < 0)
          r.status = ffba_pkg::ST_BADFREE;
        else
          free_tab[k] = 1'b1;
      end
    end else if (op == ffba_pkg::OP_REALLOC) begin
      k = find_live(addr);
      if (k < 0) begin
        r.status = ffba_pkg::ST_BADFREE;
      end else if (size_tab[k] >= size) begin
        r.address = addr;
      end else begin
        n = claim_block(size, st);
        r.status = st;
        if (n >= 0) begin
          r.address   = AW'(base_tab[n] + HDR);
          r.moved     = 1'b1;
          r.copy      = size_tab[k];
          free_tab[k] = 1'b1;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    heap_reply_t want;
    if (rst) begin
      blocks_used = 0;
      brk         = '0;
      limit_reg   = ffba_pkg::LIMIT_RESET;
      fail_count  = 0;
      replies_due.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        limit_reg = cfg_data;
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          $error("unrequested result: result_address %0d status %0d", result_address, status);
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          if (result_address !== want.address) begin
            $error("result_address: expected %0d, got %0d", want.address, result_address);
            fail_count++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fail_count++;
          end
          if (moved !== want.moved) begin
            $error("moved: expected %0d, got %0d", want.moved, moved);
            fail_count++;
          end
          if (copy_length !== want.copy) begin
            $error("copy_length: expected %0d, got %0d", want.copy, copy_length);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        replies_due.push_back(heap_step(opcode, request_size, payload_address));
    end
    pending = replies_due.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int AW = ffba_pkg::ADDR_W;
  localparam int SW = ffba_pkg::SIZE_W;
  localparam int LW = ffba_pkg::LIMIT_W;

  // cycles with no handshake on any channel before the run is declared hung
  localparam int WATCHDOG_CYCLES = 3000;
  // margin for a moving reallocate, which walks the table twice
  localparam int DRAIN_CYCLES    = 140;
  // opcode value the block does not use
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASES = 5;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_ready;
  logic [1:0]     opcode = ffba_pkg::OP_ALLOC;
  logic [SW-1:0]  request_size = '0;
  logic [AW-1:0]  payload_address = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  logic [AW-1:0]  result_address;
  logic [1:0]     status;
  logic           moved;
  logic [SW-1:0]  copy_length;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [LW-1:0]  cfg_data = '0;

  int fails;
  int replies_pending;
  int stuck_cycles = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int limit_writes = 0;
  int directed_count = 0;

  // when set, neither side inserts idle cycles
  bit steady = 1'b0;

  // payload addresses handed out and not yet given back, and ones given back
  logic [AW-1:0] live_q [$];
  logic [AW-1:0] freed_q [$];

  always #5 clk = ~clk;

  first_fit_block_allocator DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .request_size    (request_size),
    .payload_address (payload_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result_address  (result_address),
    .status          (status),
    .moved           (moved),
    .copy_length     (copy_length),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  heap_reply_checker u_heap_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .request_size    (request_size),
    .payload_address (payload_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result_address  (result_address),
    .status          (status),
    .moved           (moved),
    .copy_length     (copy_length),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .fail_count      (fails),
    .pending         (replies_pending)
  );

  // idle length: mostly none or short, now and then a long one
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (steady || pick < 55)
      return 0;
    if (pick < 92)
      return $urandom_range(1, 4);
    return $urandom_range(12, 60);
  endfunction

  // request sizes: mostly small so the table churns, a few zero or huge
  function automatic logic [SW-1:0] pick_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5)
      return '0;
    if (pick < 85)
      return SW'($urandom_range(1, 300));
    if (pick < 97)
      return SW'($urandom_range(301, 4000));
    return SW'($urandom);
  endfunction

  function automatic bit is_live(input logic [AW-1:0] addr);
    foreach (live_q[i])
      if (live_q[i] == addr)
        return 1'b1;
    return 1'b0;
  endfunction

  function automatic void forget(input logic [AW-1:0] addr);
    for (int i = 0; i < live_q.size(); i++) begin
      if (live_q[i] == addr) begin
        live_q.delete(i);
        return;
      end
    end
  endfunction

  // an address believed to be allocated; random if nothing is
  function automatic logic [AW-1:0] pick_live();
    if (live_q.size() == 0)
      return AW'($urandom);
    return live_q[$urandom_range(0, live_q.size() - 1)];
  endfunction

  // an address that is probably not a live payload: stale, misaligned or random
  function automatic logic [AW-1:0] pick_stale();
    int pick;
    pick = $urandom_range(0, 2);
    if (pick == 0 && freed_q.size() != 0)
      return freed_q[$urandom_range(0, freed_q.size() - 1)];
    if (pick == 1)
      return pick_live() + AW'(1);
    return AW'($urandom);
  endfunction

  // one request, called and returning at a falling edge; valid stays up after
  // acceptance so a back-to-back request needs no drop
  task automatic send(input logic [1:0] op, input logic [SW-1:0] size,
                      input logic [AW-1:0] addr);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        = 1'b1;
    opcode          = op;
    request_size    = size;
    payload_address = addr;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    @(negedge clk);
    requests_sent++;
    // the caller gives this block up; its result puts it back if it survives
    if ((op == ffba_pkg::OP_FREE || op == ffba_pkg::OP_REALLOC) && addr != '0) begin
      forget(addr);
      if (op == ffba_pkg::OP_FREE)
        freed_q.push_back(addr);
    end
  endtask

  // heap limit writes only once every result is back and the block is quiet
  task automatic set_heap_limit(input logic [LW-1:0] lim);
    in_valid = 1'b0;
    while (replies_pending != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = lim;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    limit_writes++;
  endtask

  // result side: ready in bursts, stalls mostly short with a few long ones
  initial begin : result_sink
    int run;
    forever begin
      if (steady || $urandom_range(0, 2) != 0) begin
        out_ready = 1'b1;
        run = $urandom_range(1, 8);
      end else begin
        out_ready = 1'b0;
        run = idle_len();
        if (run == 0)
          run = 1;
      end
      repeat (run) @(negedge clk);
    end
  end

  // collect handed-out addresses to drive later free and reallocate requests
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (status == ffba_pkg::ST_OK && result_address != '0 && !is_live(result_address))
        live_q.push_back(result_address);
    end
  end

  // hang detection: no request, result or register write for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == WATCHDOG_CYCLES) begin
        $display("timeout: no handshake for %0d cycles", WATCHDOG_CYCLES);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [LW-1:0] limits [PHASES];
    int            quota [PHASES];
    int            counted;
    int            pick;

    // tight limit first so growth runs into it before the table fills,
    // then above the address span, zero, just under the span, and random
    limits[0] = LW'(3000);
    limits[1] = '1;
    limits[2] = '0;
    limits[3] = LW'(20'hFFFFF);
    limits[4] = LW'($urandom_range(0, 21'h1FFFFF));
    quota[0] = 70;
    quota[1] = 110;
    quota[2] = 40;
    quota[3] = 120;
    quota[4] = 110;

    repeat (4) @(negedge clk);
    rst = 1'b0;

    // directed part under the reset limit; addresses follow from a 24-byte header
    send(ffba_pkg::OP_ALLOC, '0, '0);                  // zero-size allocate
    send(ffba_pkg::OP_FREE, '0, '0);                   // null free
    send(ffba_pkg::OP_FREE, '0, 20'hFFFFF);            // free into an empty table
    send(ffba_pkg::OP_REALLOC, 20'd5, 20'd24);         // reallocate of an unknown block
    send(ffba_pkg::OP_ALLOC, 20'hFFFFF, '0);           // larger than the whole heap
    send(ffba_pkg::OP_ALLOC, 20'd100, '0);             // first block, payload at 24
    send(ffba_pkg::OP_ALLOC, 20'd1, '0);               // payload at 148
    send(ffba_pkg::OP_ALLOC, 20'd300, '0);             // payload at 173
    send(ffba_pkg::OP_FREE, '0, 20'd24);               // plain free
    send(ffba_pkg::OP_FREE, '0, 20'd24);               // double free
    send(ffba_pkg::OP_REALLOC, 20'd10, 20'd24);        // reallocate of a freed block
    send(ffba_pkg::OP_ALLOC, 20'd50, '0);              // first fit takes the 100-byte hole
    send(ffba_pkg::OP_REALLOC, 20'd100, 20'd24);       // grows within its own block
    send(ffba_pkg::OP_REALLOC, '0, 20'd24);            // shrink to zero keeps the block
    send(ffba_pkg::OP_REALLOC, 20'd500, 20'd148);      // must move, one byte to copy
    send(ffba_pkg::OP_REALLOC, 20'd40, '0);            // null reallocate acts as allocate
    send(ffba_pkg::OP_REALLOC, '0, '0);                // null reallocate of zero size
    send(OP_UNUSED, 20'hFFFFF, 20'hFFFFF);             // unused opcode is ignored
    send(ffba_pkg::OP_FREE, '0, 20'd25);               // not a payload address
    send(ffba_pkg::OP_REALLOC, 20'hFFFFF, 20'd24);     // failed move, old block stays
    send(ffba_pkg::OP_FREE, 20'hFFFFF, 20'd173);       // size field ignored on free
    directed_count = requests_sent;

    for (int p = 0; p < PHASES; p++) begin
      set_heap_limit(limits[p]);
      // one phase runs both sides flat out
      steady  = (p == 3);
      counted = 0;
      while (counted < quota[p]) begin
        pick = $urandom_range(0, 99);
        if (pick < 40)
          send(ffba_pkg::OP_ALLOC, pick_size(), AW'($urandom));
        else if (pick < 63)
          send(ffba_pkg::OP_FREE, SW'($urandom), pick_live());
        else if (pick < 70)
          send(ffba_pkg::OP_FREE, SW'($urandom), pick_stale());
        else if (pick < 88)
          send(ffba_pkg::OP_REALLOC, pick_size(), pick_live());
        else if (pick < 92)
          send(ffba_pkg::OP_REALLOC, pick_size(), pick_stale());
        else if (pick < 95)
          send(ffba_pkg::OP_REALLOC, pick_size(), '0);
        else if (pick < 97)
          send(ffba_pkg::OP_FREE, SW'($urandom), '0);
        else
          send(OP_UNUSED, SW'($urandom), AW'($urandom));
        // ignored opcodes do not count toward the phase
        if (pick < 97)
          counted++;
      end
    end
    steady   = 1'b0;
    in_valid = 1'b0;

    // wait for the last results, then watch for strays a little longer
    while (replies_pending != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d requests (%0d directed), %0d results compared",
             requests_sent, directed_count, results_seen);
    $display("heap limit set %0d times, from zero to beyond the address span", limit_writes);
    if (fails == 0 && replies_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
